### hw/rtl/ledps_pkg.sv
`default_nettype none

package ledps_pkg;

    localparam int PATTERN_STEPS_DEF = 16;
    localparam int TIME_BITS_DEF     = 32;

    localparam int INTERVAL_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [INTERVAL_BITS-1:0] STARTUP_INTERVAL_RST  = 16'd100;
    localparam logic [INTERVAL_BITS-1:0] STANDARD_INTERVAL_RST = 16'd200;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STARTUP_INTERVAL  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STANDARD_INTERVAL = 1'd1;

    localparam logic [1:0] SRC_MAIN  = 2'd0;
    localparam logic [1:0] SRC_CLOCK = 2'd1;

    localparam logic [3:0] SIG_BANG    = 4'd0;
    localparam logic [3:0] SIG_CLK_IN  = 4'd1;
    localparam logic [3:0] SIG_CLK_OUT = 4'd2;
    localparam logic [3:0] SIG_SET1    = 4'd3;
    localparam logic [3:0] SIG_SET16   = 4'd7;

    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] LEVEL_OFF  = 8'd0;

    typedef enum logic [2:0] {
        MODE_STARTUP = 3'd0,
        MODE_CLOCK   = 3'd1,
        MODE_NONE    = 3'd2,
        MODE_CONF1   = 3'd3,
        MODE_CONF2   = 3'd4,
        MODE_CONF4   = 3'd5,
        MODE_CONF8   = 3'd6,
        MODE_CONF16  = 3'd7
    } mode_t;

    typedef struct packed {
        logic  drop;
        mode_t mode_next;
        mode_t follow_next;
    } step_ctl_t;

    localparam logic [7:0] PATTERN_ROM [6][16] = '{
        '{8'd12, 8'd35, 8'd80, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
          8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255},
        '{8'd35, 8'd80, 8'd35, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd35, 8'd80, 8'd35, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd35, 8'd80, 8'd35, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0,
          8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd35, 8'd80, 8'd35, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
          8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd35, 8'd80, 8'd35, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255,
          8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0}
    };

    function automatic logic [7:0] pattern_level(mode_t m, logic [3:0] idx);
        logic [7:0] level;
        level = LEVEL_OFF;
        case (m)
            MODE_STARTUP: level = PATTERN_ROM[0][idx];
            MODE_CONF1:   level = PATTERN_ROM[1][idx];
            MODE_CONF2:   level = PATTERN_ROM[2][idx];
            MODE_CONF4:   level = PATTERN_ROM[3][idx];
            MODE_CONF8:   level = PATTERN_ROM[4][idx];
            MODE_CONF16:  level = PATTERN_ROM[5][idx];
            default:      level = LEVEL_OFF;
        endcase
        return level;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ledps_step.sv
`default_nettype none

module ledps_step
    import ledps_pkg::*;
#(
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF,
    localparam int STEP_BITS    = $clog2(PATTERN_STEPS)
) (
    input  var mode_t                    mode,
    input  var mode_t                    follow_mode,
    input  wire logic [STEP_BITS-1:0]    step_index,
    input  wire logic [TIME_BITS-1:0]    deadline_ms,
    input  wire logic [1:0]              req_type,
    input  wire logic [3:0]              event_signal,
    input  wire logic [31:0]             now_ms,
    input  wire logic [INTERVAL_BITS-1:0] startup_interval,
    input  wire logic [INTERVAL_BITS-1:0] standard_interval,
    output step_ctl_t                    ctl,
    output logic [STEP_BITS-1:0]         step_next,
    output logic [TIME_BITS-1:0]         deadline_next,
    output logic [7:0]                   brightness
);

    localparam int IDX_BITS = (STEP_BITS > 4) ? STEP_BITS : 4;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] due_startup;
    logic [TIME_BITS-1:0] due_standard;
    logic [IDX_BITS-1:0]  step_wide;
    logic [3:0]           rom_idx;
    logic                 is_set;
    mode_t                picked;
    mode_t                confirm;

    assign now_t        = TIME_BITS'(now_ms);
    assign due_startup  = now_t + TIME_BITS'(startup_interval);
    assign due_standard = now_t + TIME_BITS'(standard_interval);
    assign step_wide    = IDX_BITS'(step_index);
    assign rom_idx      = step_wide[3:0];

    always_comb
    begin
        is_set = (req_type == SRC_CLOCK) && (event_signal inside {[SIG_SET1:SIG_SET16]});
        picked = mode_t'(3'(event_signal - SIG_SET1 + 4'(MODE_CONF1)));
        confirm = is_set ? picked : MODE_NONE;

        ctl.drop = ((deadline_ms > now_t) && (req_type == SRC_MAIN) &&
                    (event_signal == SIG_BANG)) ||
                   ((mode != MODE_CLOCK) && (req_type == SRC_CLOCK) &&
                    ((event_signal == SIG_CLK_IN) || (event_signal == SIG_CLK_OUT)));

        ctl.follow_next = follow_mode;
        ctl.mode_next   = mode;
        deadline_next   = due_startup;
        brightness      = LEVEL_OFF;
        picked          = confirm;

        case (mode)
            MODE_STARTUP:
            begin
                brightness      = pattern_level(mode, rom_idx);
                ctl.follow_next = MODE_NONE;
                picked          = MODE_NONE;
            end
            MODE_CLOCK:
            begin
                picked = (event_signal != SIG_CLK_IN) ? confirm : MODE_NONE;
                if ((req_type == SRC_CLOCK) && (event_signal == SIG_CLK_IN))
                begin
                    brightness = LEVEL_FULL;
                end
                deadline_next = due_standard;
            end
            MODE_NONE:
            begin
                picked = confirm;
            end
            default:
            begin
                picked          = confirm;
                ctl.follow_next = MODE_CLOCK;
                deadline_next   = due_standard;
                brightness      = pattern_level(mode, rom_idx);
            end
        endcase

        if ((picked != MODE_NONE) && (picked != mode))
        begin
            step_next     = '0;
            ctl.mode_next = picked;
        end
        else if (step_index >= STEP_BITS'(PATTERN_STEPS - 1))
        begin
            step_next     = '0;
            ctl.mode_next = ctl.follow_next;
        end
        else
        begin
            step_next = step_index + STEP_BITS'(1);
        end
    end

endmodule

`default_nettype wire

### hw/rtl/led_pattern_mode_sequencer.sv
// LED pattern mode sequencer.
// Input stream (s_*): one event per request, fields packed in s_tdata.
// Output stream (m_*): one brightness result per event that is not dropped;
// an early main bang and a stray clock in/out outside clock mode give none.
// Configuration channel (cfg_*): index 0 startup interval, 1 standard
// interval; always ready, writes take effect at the next edge.
// An accepted event waits in the input register until its result moves to
// the output register, which drives m_tvalid; a stalled output delays this.
// Throughput: one event per cycle unless the output stalls; the mode state
// updates as an emitted (not dropped) event leaves the input register, so
// the next event sees it immediately.
// A stalled m_tready holds the result; the input register still fills, and
// s_tready drops once both registers are full (dropped events still drain).
// Reset: mode startup, follow-on mode none, step zero, deadline zero,
// intervals 100 and 200 ms, both registers empty.
`default_nettype none

module led_pattern_mode_sequencer
    import ledps_pkg::*;
#(
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF,
    parameter int TIME_BITS     = TIME_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // req_type[1:0], event_signal[5:2], now_ms[37:6], zero[39:38]
    input  wire logic [39:0]               s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // brightness[7:0], mode_now[10:8], zero[15:11]
    output logic [15:0]                    m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [INTERVAL_BITS-1:0]  cfg_data
);

    localparam int STEP_BITS = $clog2(PATTERN_STEPS);

    logic                      in_valid_reg;
    logic [1:0]                req_type_reg;
    logic [3:0]                event_signal_reg;
    logic [31:0]               now_ms_reg;
    logic                      out_valid_reg;
    logic [7:0]                brightness_reg;
    mode_t                     mode_now_reg;
    logic [INTERVAL_BITS-1:0]  startup_interval_reg;
    logic [INTERVAL_BITS-1:0]  standard_interval_reg;
    mode_t                     mode_reg;
    mode_t                     follow_mode_reg;
    logic [STEP_BITS-1:0]      step_index_reg;
    logic [TIME_BITS-1:0]      deadline_ms_reg;

    step_ctl_t                 ctl;
    logic [STEP_BITS-1:0]      step_next;
    logic [TIME_BITS-1:0]      deadline_next;
    logic [7:0]                brightness_next;
    logic                      advance;
    logic                      emit;

    assign advance   = in_valid_reg && (ctl.drop || !out_valid_reg || m_tready);
    assign emit      = advance && !ctl.drop;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, mode_now_reg, brightness_reg};
    assign cfg_ready = 1'b1;

    ledps_step #(
        .PATTERN_STEPS(PATTERN_STEPS),
        .TIME_BITS    (TIME_BITS)
    ) u_step (
        .mode             (mode_reg),
        .follow_mode      (follow_mode_reg),
        .step_index       (step_index_reg),
        .deadline_ms      (deadline_ms_reg),
        .req_type         (req_type_reg),
        .event_signal     (event_signal_reg),
        .now_ms           (now_ms_reg),
        .startup_interval (startup_interval_reg),
        .standard_interval(standard_interval_reg),
        .ctl              (ctl),
        .step_next        (step_next),
        .deadline_next    (deadline_next),
        .brightness       (brightness_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            startup_interval_reg  <= STARTUP_INTERVAL_RST;
            standard_interval_reg <= STANDARD_INTERVAL_RST;
            mode_reg              <= MODE_STARTUP;
            follow_mode_reg       <= MODE_NONE;
            step_index_reg        <= '0;
            deadline_ms_reg       <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                mode_reg        <= ctl.mode_next;
                follow_mode_reg <= ctl.follow_next;
                step_index_reg  <= step_next;
                deadline_ms_reg <= deadline_next;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STARTUP_INTERVAL:  startup_interval_reg  <= cfg_data;
                    CFG_STANDARD_INTERVAL: standard_interval_reg <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_type_reg     <= s_tdata[1:0];
            event_signal_reg <= s_tdata[5:2];
            now_ms_reg       <= s_tdata[37:6];
        end
        if (emit)
        begin
            brightness_reg <= brightness_next;
            mode_now_reg   <= ctl.mode_next;
        end
    end

endmodule

`default_nettype wire
